// ===== design/ces_pkg.sv =====
// Shared types and constants for the chain energy block.
`timescale 1ns / 1ps
package ces_pkg;

  localparam int MUL_A_W = 68;
  localparam int MUL_B_W = 34;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 62;
  localparam int DIV_D_W = 33;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [63:0] ONE60 = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] NEG_ONE60 = -64'sh1000_0000_0000_0000;
  localparam logic [23:0] CFG_ONE = 24'h01_0000;

  localparam logic [1:0] REG_SPRING = 2'd0;
  localparam logic [1:0] REG_REST   = 2'd1;
  localparam logic [1:0] REG_BEND   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_START,
    S_SQ_WAIT,
    S_ROOT,
    S_DEV_START,
    S_DEV_WAIT,
    S_SPR_START,
    S_SPR_WAIT,
    S_U0_START,
    S_U0_WAIT,
    S_U1_START,
    S_U1_WAIT,
    S_UP_START,
    S_UP_WAIT,
    S_BEND_START,
    S_BEND_WAIT,
    S_FINISH
  } state_t;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] t;
    t = v[32] ? 33'(-v) : 33'(v);
    return t[31:0];
  endfunction

endpackage

// ===== design/ces_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module ces_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ces_pkg::MUL_A_W-1:0] a,
  input  logic [ces_pkg::MUL_B_W-1:0] b,
  output logic                        done,
  output logic [ces_pkg::MUL_P_W-1:0] prod
);

  logic [ces_pkg::MUL_A_W-1:0] a_hold;
  logic [5:0]                  cnt;
  logic                        busy;
  logic [ces_pkg::MUL_A_W:0]   sum;

  assign sum = {1'b0, prod[ces_pkg::MUL_P_W-1:ces_pkg::MUL_B_W]} +
               (prod[0] ? {1'b0, a_hold} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(ces_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      prod   <= {{ces_pkg::MUL_A_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {sum, prod[ces_pkg::MUL_B_W-1:1]};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier restarted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy && cnt == 6'd0)
    else $error("multiplier did not start");

endmodule

// ===== design/ces_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ces_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ces_pkg::DIV_N_W-1:0] num,
  input  logic [ces_pkg::DIV_D_W-1:0] den,
  output logic                        done,
  output logic [ces_pkg::DIV_N_W-1:0] quo
);

  logic [ces_pkg::DIV_D_W-1:0] den_hold;
  logic [ces_pkg::DIV_D_W-1:0] rem;
  logic [ces_pkg::DIV_D_W:0]   rem_sh;
  logic [ces_pkg::DIV_D_W:0]   rem_sub;
  logic [5:0]                  cnt;
  logic                        busy;

  assign rem_sh  = {rem, quo[ces_pkg::DIV_N_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(ces_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_hold <= den;
      rem      <= '0;
      quo      <= num;
    end else if (busy) begin
      if (rem_sh >= {1'b0, den_hold}) begin
        rem <= rem_sub[ces_pkg::DIV_D_W-1:0];
        quo <= {quo[ces_pkg::DIV_N_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[ces_pkg::DIV_D_W-1:0];
        quo <= {quo[ces_pkg::DIV_N_W-2:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt < 6'(ces_pkg::DIV_N_W))
    else $error("divider count out of range");

endmodule

// ===== design/chain_energy_spring_bend.sv =====
// Bead-spring chain energy: harmonic bond and cosine bending terms, Q32.16 sum.
//
// Beads arrive one per transfer on s_tdata (x, y, z, signed Q16.16), with s_tlast
// marking the final bead; that bead's transfer produces one result carrying the
// saturating Q32.16 total and the degenerate/saturated flags. Work is done by a
// bit-serial multiplier, a restoring divider and a two-bit-per-cycle square
// root, all driven by one sequencer, so a bead is processed one at a time: the
// first bead of a chain goes straight to its finish step, a second bead runs
// three squares, the root and two products, and each later bead adds six
// divides and four products unless either bond length is zero. A waiting result
// does not block the next bead; only a second final bead waits in its last
// cycle until the previous result is taken.
`timescale 1ns / 1ps
module chain_energy_spring_bend (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  logic        s_tlast,   // last_bead
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // total_energy [47:0]
  output logic [1:0]  m_tuser,   // degenerate [0], saturated [1]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  ces_pkg::state_t state, state_next;

  logic [23:0] spring_const, rest_length, bend_const;

  logic [31:0]        prev [0:2];
  logic signed [32:0] dcur [0:2];
  logic signed [32:0] dprev [0:2];
  logic [32:0]        nprev;
  logic               last;
  logic [1:0]         idx;
  logic [1:0]         beads;
  logic [1:0]         flags;
  logic [47:0]        energy;

  logic [65:0]        s_acc;
  logic [65:0]        sq_sh;
  logic [35:0]        rem;
  logic [32:0]        root;
  logic [5:0]         cnt;
  logic [67:0]        d2;
  logic [31:0]        u0;
  logic signed [63:0] ct;

  logic                         mul_start, mul_done;
  logic [ces_pkg::MUL_A_W-1:0]  mul_a;
  logic [ces_pkg::MUL_B_W-1:0]  mul_b;
  logic [ces_pkg::MUL_P_W-1:0]  mul_prod;
  logic                         div_start, div_done;
  logic [ces_pkg::DIV_N_W-1:0]  div_num;
  logic [ces_pkg::DIV_D_W-1:0]  div_den;
  logic [ces_pkg::DIV_N_W-1:0]  div_quo;

  logic [65:0]        sq_sum;
  logic [35:0]        rem_sh, trial;
  logic signed [34:0] dev;
  logic [68:0]        spr_v;
  logic [47:0]        term;
  logic               term_sat;
  logic               term_en;
  logic [48:0]        acc_sum;
  logic signed [63:0] ct_clamp, w_full;
  logic               bend_ok;
  logic               proceed;

  assign s_tready = (state == ces_pkg::S_IDLE);
  assign proceed  = !last || !m_tvalid || m_tready;
  assign bend_ok  = (beads == 2'd2) && (nprev != '0) && (root != '0);

  assign sq_sum = s_acc + mul_prod[65:0];
  assign rem_sh = {rem[33:0], sq_sh[65:64]};
  assign trial  = {1'b0, root, 2'b01};
  assign dev    = $signed({2'b0, root}) - $signed({11'b0, rest_length});
  assign spr_v  = mul_prod[101:33];

  always_comb begin
    ct_clamp = ct;
    if (ct > ces_pkg::ONE60) begin
      ct_clamp = ces_pkg::ONE60;
    end else if (ct < ces_pkg::NEG_ONE60) begin
      ct_clamp = ces_pkg::NEG_ONE60;
    end
    w_full = ces_pkg::ONE60 - ct_clamp;
  end

  always_comb begin
    term     = '0;
    term_sat = 1'b0;
    term_en  = 1'b0;
    if (state == ces_pkg::S_SPR_WAIT && mul_done) begin
      term_en = 1'b1;
      if (spr_v[68:48] != '0) begin
        term     = ces_pkg::MAX48;
        term_sat = 1'b1;
      end else begin
        term = spr_v[47:0];
      end
    end else if (state == ces_pkg::S_BEND_WAIT && mul_done) begin
      term_en = 1'b1;
      term    = mul_prod[77:30];
    end
    acc_sum = {1'b0, energy} + {1'b0, term};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ces_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = '0;
    div_den    = '0;
    unique case (state)
      ces_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = (beads == 2'd0) ? ces_pkg::S_FINISH : ces_pkg::S_SQ_START;
        end
      end
      ces_pkg::S_SQ_START: begin
        mul_start  = 1'b1;
        mul_a      = {36'b0, ces_pkg::mag33(dcur[idx])};
        mul_b      = {2'b0, ces_pkg::mag33(dcur[idx])};
        state_next = ces_pkg::S_SQ_WAIT;
      end
      ces_pkg::S_SQ_WAIT: begin
        if (mul_done) begin
          state_next = (idx == 2'd2) ? ces_pkg::S_ROOT : ces_pkg::S_SQ_START;
        end
      end
      ces_pkg::S_ROOT: begin
        if (cnt == 6'd32) begin
          state_next = ces_pkg::S_DEV_START;
        end
      end
      ces_pkg::S_DEV_START: begin
        mul_start  = 1'b1;
        mul_a      = {34'b0, (dev[34] ? 34'(-dev) : 34'(dev))};
        mul_b      = dev[34] ? 34'(-dev) : 34'(dev);
        state_next = ces_pkg::S_DEV_WAIT;
      end
      ces_pkg::S_DEV_WAIT: begin
        if (mul_done) begin
          state_next = ces_pkg::S_SPR_START;
        end
      end
      ces_pkg::S_SPR_START: begin
        mul_start  = 1'b1;
        mul_a      = d2;
        mul_b      = {10'b0, spring_const};
        state_next = ces_pkg::S_SPR_WAIT;
      end
      ces_pkg::S_SPR_WAIT: begin
        if (mul_done) begin
          state_next = bend_ok ? ces_pkg::S_U0_START : ces_pkg::S_FINISH;
        end
      end
      ces_pkg::S_U0_START: begin
        div_start  = 1'b1;
        div_num    = {ces_pkg::mag33(dprev[idx]), 30'b0};
        div_den    = nprev;
        state_next = ces_pkg::S_U0_WAIT;
      end
      ces_pkg::S_U0_WAIT: begin
        if (div_done) begin
          state_next = ces_pkg::S_U1_START;
        end
      end
      ces_pkg::S_U1_START: begin
        div_start  = 1'b1;
        div_num    = {ces_pkg::mag33(dcur[idx]), 30'b0};
        div_den    = root;
        state_next = ces_pkg::S_U1_WAIT;
      end
      ces_pkg::S_U1_WAIT: begin
        if (div_done) begin
          state_next = ces_pkg::S_UP_START;
        end
      end
      ces_pkg::S_UP_START: begin
        mul_start  = 1'b1;
        mul_a      = {36'b0, u0};
        mul_b      = {2'b0, div_quo[31:0]};
        state_next = ces_pkg::S_UP_WAIT;
      end
      ces_pkg::S_UP_WAIT: begin
        if (mul_done) begin
          state_next = (idx == 2'd2) ? ces_pkg::S_BEND_START : ces_pkg::S_U0_START;
        end
      end
      ces_pkg::S_BEND_START: begin
        mul_start  = 1'b1;
        mul_a      = {36'b0, w_full[61:30]};
        mul_b      = {10'b0, bend_const};
        state_next = ces_pkg::S_BEND_WAIT;
      end
      ces_pkg::S_BEND_WAIT: begin
        if (mul_done) begin
          state_next = ces_pkg::S_FINISH;
        end
      end
      ces_pkg::S_FINISH: begin
        if (proceed) begin
          state_next = ces_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ces_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_const <= ces_pkg::CFG_ONE;
      rest_length  <= ces_pkg::CFG_ONE;
      bend_const   <= ces_pkg::CFG_ONE;
    end else if (cfg_we) begin
      if (cfg_index == ces_pkg::REG_SPRING) spring_const <= cfg_data;
      if (cfg_index == ces_pkg::REG_REST)   rest_length  <= cfg_data;
      if (cfg_index == ces_pkg::REG_BEND)   bend_const   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beads    <= '0;
      flags    <= '0;
      energy   <= '0;
      m_tvalid <= 1'b0;
      idx      <= '0;
      cnt      <= '0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
      end
    end else begin
      if (state == ces_pkg::S_FINISH && proceed && last) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (term_en) begin
        energy <= acc_sum[48] ? ces_pkg::MAX48 : acc_sum[47:0];
        flags  <= flags | {acc_sum[48] | term_sat,
                           (state == ces_pkg::S_SPR_WAIT) && (root == '0)};
      end
      unique case (state)
        ces_pkg::S_IDLE: begin
          if (s_tvalid) begin
            last  <= s_tlast;
            idx   <= '0;
            s_acc <= '0;
            for (int i = 0; i < 3; i++) begin
              dcur[i] <= $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]}) -
                         $signed({prev[i][31], prev[i]});
              prev[i] <= s_tdata[32*i +: 32];
            end
          end
        end
        ces_pkg::S_SQ_WAIT: begin
          if (mul_done) begin
            s_acc <= sq_sum;
            idx   <= idx + 2'd1;
            if (idx == 2'd2) begin
              sq_sh <= sq_sum;
              rem   <= '0;
              root  <= '0;
              cnt   <= '0;
            end
          end
        end
        ces_pkg::S_ROOT: begin
          cnt   <= cnt + 6'd1;
          sq_sh <= {sq_sh[63:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[31:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[31:0], 1'b0};
          end
        end
        ces_pkg::S_DEV_WAIT: begin
          if (mul_done) begin
            d2 <= mul_prod[67:0];
          end
        end
        ces_pkg::S_SPR_WAIT: begin
          if (mul_done) begin
            idx <= '0;
            ct  <= '0;
          end
        end
        ces_pkg::S_U0_WAIT: begin
          if (div_done) begin
            u0 <= div_quo[31:0];
          end
        end
        ces_pkg::S_UP_WAIT: begin
          if (mul_done) begin
            idx <= idx + 2'd1;
            if (dprev[idx][32] ^ dcur[idx][32]) begin
              ct <= ct - $signed({2'b0, mul_prod[61:0]});
            end else begin
              ct <= ct + $signed({2'b0, mul_prod[61:0]});
            end
          end
        end
        ces_pkg::S_FINISH: begin
          if (proceed) begin
            if (beads != 2'd0) begin
              for (int i = 0; i < 3; i++) begin
                dprev[i] <= dcur[i];
              end
              nprev <= root;
            end
            if (last) begin
              m_tdata  <= energy;
              m_tuser  <= flags;
              beads    <= '0;
              flags    <= '0;
              energy   <= '0;
              for (int i = 0; i < 3; i++) begin
                prev[i] <= '0;
              end
            end else if (beads != 2'd2) begin
              beads <= beads + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  ces_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ces_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assert property (@(posedge clk) disable iff (rst) beads != 2'd3)
    else $error("bead count out of range");
  assert property (@(posedge clk) disable iff (rst)
    (state == ces_pkg::S_FINISH && proceed && last) |=> beads == 2'd0 && energy == '0)
    else $error("chain state not cleared after final bead");
  assert property (@(posedge clk) disable iff (rst)
    (state == ces_pkg::S_FINISH && last && !proceed) |=> state == ces_pkg::S_FINISH)
    else $error("final bead left while result slot busy");
  assert property (@(posedge clk) disable iff (rst)
    state == ces_pkg::S_ROOT |-> cnt <= 6'd32)
    else $error("square root ran past its last step");

endmodule

// ===== tb/tb_chain_energy_spring_bend.sv =====
// Self-checking testbench for the bead-spring chain energy block.
`timescale 1ns / 1ps
module tb_chain_energy_spring_bend;

  localparam int  SETTLE_CYCLES = 1000;
  localparam int  HOLD_CYCLES   = 20000;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct {
    logic [31:0] x, y, z;
    logic        last;
  } bead_t;

  typedef struct {
    logic [47:0] energy;
    logic        degen;
    logic        sat;
  } energy_t;

  typedef struct {
    longint x, y, z;
  } vec3_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = ces_pkg::REG_SPRING;
  logic [23:0] cfg_data = '0;

  bead_t   bead_q[$];
  energy_t energy_q[$];
  bead_t   cur_bead;
  int      beads_open = 0;
  int      errors = 0;
  longint  cycles = 0;
  bit      quiet = 0;
  bit      hold_go = 0;
  bit      hold_done = 0;
  int      hold_cnt = 0;
  int      in_gap = 0;
  int      out_gap = 0;

  // predictor state
  logic [23:0] ks, l0, kb;
  logic [31:0] prev_pos[3], pprev_pos[3];
  logic [63:0] esum;
  int          nseen;
  bit          fl_degen, fl_sat;

  chain_energy_spring_bend i_dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic vec3_t bond_vec(logic [31:0] a[3], logic [31:0] b[3]);
    vec3_t d;
    d.x = longint'($signed(b[0])) - longint'($signed(a[0]));
    d.y = longint'($signed(b[1])) - longint'($signed(a[1]));
    d.z = longint'($signed(b[2])) - longint'($signed(a[2]));
    return d;
  endfunction

  function automatic logic [67:0] sq68(longint v);
    logic [67:0] m;
    m = 68'(v < 0 ? -v : v);
    return m * m;
  endfunction

  function automatic logic [67:0] bond_len(vec3_t d);
    logic [67:0] s, rem, root, trial;
    s = sq68(d.x) + sq68(d.y) + sq68(d.z);
    rem = 0;
    root = 0;
    for (int p = 33; p >= 0; p--) begin
      rem = (rem << 2) | ((s >> (2 * p)) & 68'd3);
      trial = (root << 2) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 68'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] spring_energy(logic [67:0] r, output bit sat);
    longint dev;
    logic [127:0] m, p;
    dev = longint'(r) - longint'(l0);
    m = 128'(dev < 0 ? -dev : dev);
    p = ((m * m) * 128'(ks)) >> 33;
    sat = p > 128'(ces_pkg::MAX48);
    return sat ? 64'(ces_pkg::MAX48) : p[63:0];
  endfunction

  function automatic longint unit_part(longint d, logic [67:0] n);
    longint q;
    q = longint'((68'(d < 0 ? -d : d) << 30) / n);
    return d < 0 ? -q : q;
  endfunction

  function automatic logic [63:0] bend_energy(vec3_t d0, logic [67:0] n0,
                                              vec3_t d1, logic [67:0] n1);
    longint ct;
    logic [63:0] u;
    if (n0 == 0 || n1 == 0) return 0;
    ct = unit_part(d0.x, n0) * unit_part(d1.x, n1) + unit_part(d0.y, n0) * unit_part(d1.y, n1)
       + unit_part(d0.z, n0) * unit_part(d1.z, n1);
    if (ct > ces_pkg::ONE60) ct = ces_pkg::ONE60;
    if (ct < ces_pkg::NEG_ONE60) ct = ces_pkg::NEG_ONE60;
    u = 64'(ces_pkg::ONE60 - ct) >> 30;
    return (64'(kb) * u) >> 30;
  endfunction

  function automatic void add_energy(logic [63:0] e);
    esum = esum + e;
    if (esum > 64'(ces_pkg::MAX48)) begin
      esum = 64'(ces_pkg::MAX48);
      fl_sat = 1;
    end
  endfunction

  function automatic void clear_chain();
    for (int i = 0; i < 3; i++) begin
      prev_pos[i] = 0;
      pprev_pos[i] = 0;
    end
    esum = 0;
    nseen = 0;
    fl_degen = 0;
    fl_sat = 0;
  endfunction

  function automatic void predict_bead(bead_t b);
    logic [31:0] pos[3];
    vec3_t d0, d1;
    logic [67:0] n0, n1;
    bit sat;
    energy_t res;
    pos[0] = b.x;
    pos[1] = b.y;
    pos[2] = b.z;
    if (nseen >= 1) begin
      d1 = bond_vec(prev_pos, pos);
      n1 = bond_len(d1);
      if (n1 == 0) fl_degen = 1;
      add_energy(spring_energy(n1, sat));
      if (sat) fl_sat = 1;
      if (nseen >= 2) begin
        d0 = bond_vec(pprev_pos, prev_pos);
        n0 = bond_len(d0);
        add_energy(bend_energy(d0, n0, d1, n1));
      end
    end
    pprev_pos = prev_pos;
    prev_pos = pos;
    if (nseen < 2) nseen++;
    if (b.last) begin
      res.energy = esum[47:0];
      res.degen = fl_degen;
      res.sat = fl_sat;
      energy_q.push_back(res);
      clear_chain();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    bit nv;
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      nv = s_tvalid;
      if (s_tvalid && s_tready) begin
        predict_bead(cur_bead);
        beads_open--;
        nv = 0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 10);
        end else if (bead_q.size() > 0) begin
          cur_bead = bead_q.pop_front();
          s_tdata <= {cur_bead.z, cur_bead.y, cur_bead.x};
          s_tlast <= cur_bead.last;
          nv = 1;
        end
      end
      s_tvalid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    energy_t e;
    bit nr;
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (energy_q.size() == 0) begin
          $error("unexpected result energy=%h flags=%b", m_tdata, m_tuser);
          errors++;
        end else begin
          e = energy_q.pop_front();
          if (m_tdata !== e.energy) begin
            $error("total_energy expected %h actual %h", e.energy, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== e.degen) begin
            $error("degenerate expected %b actual %b", e.degen, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== e.sat) begin
            $error("saturated expected %b actual %b", e.sat, m_tuser[1]);
            errors++;
          end
        end
      end
      nr = 1;
      if (hold_go && !hold_done) begin
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
        nr = 0;
      end else if (out_gap > 0) begin
        out_gap--;
        nr = 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 10);
        nr = 0;
      end
      m_tready <= nr;
    end
  end

  task automatic push_bead(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    bead_t b;
    b.x = x;
    b.y = y;
    b.z = z;
    b.last = last;
    bead_q.push_back(b);
    beads_open++;
  endtask

  function automatic logic [31:0] step32();
    return 32'($urandom_range(0, 32'h6_0000)) - 32'h3_0000;
  endfunction

  function automatic logic [31:0] corner32();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic random_chain(inout int count);
    int n;
    logic [31:0] x, y, z;
    n = $urandom_range(1, 10);
    x = $urandom;
    y = $urandom;
    z = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: ;
        1: begin
          x = $urandom; y = $urandom; z = $urandom;
        end
        2: begin
          x = corner32(); y = corner32(); z = corner32();
        end
        3: begin
          x = x + ($urandom << 12); y = y - ($urandom << 12); z = z + step32();
        end
        default: begin
          x = x + step32(); y = y + step32(); z = z + step32();
        end
      endcase
      push_bead(x, y, z, i == n - 1);
    end
    count += n;
  endtask

  task automatic drain();
    do @(posedge clk); while (beads_open != 0 || energy_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [23:0] spring, logic [23:0] rest, logic [23:0] bend);
    logic [23:0] vals[3];
    vals[0] = spring;
    vals[1] = rest;
    vals[2] = bend;
    for (int i = 0; i < 3; i++) begin
      @(posedge clk);
      cfg_we <= 1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
    end
    ks = spring;
    l0 = rest;
    kb = bend;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int items);
    int count;
    count = 0;
    while (count < items) random_chain(count);
    drain();
  endtask

  initial begin
    ks = ces_pkg::CFG_ONE;
    l0 = ces_pkg::CFG_ONE;
    kb = ces_pkg::CFG_ONE;
    clear_chain();
    repeat (3) @(posedge clk);
    rst <= 0;

    // single bead, straight line, reversal, duplicate, extremes
    push_bead(32'h1234_5678, 32'h0, 32'h0, 1);
    push_bead(32'h0, 32'h0, 32'h0, 0);
    push_bead(32'h1_0000, 32'h0, 32'h0, 0);
    push_bead(32'h2_0000, 32'h0, 32'h0, 1);
    push_bead(32'h0, 32'h0, 32'h0, 0);
    push_bead(32'h0, 32'h1_8000, 32'h0, 0);
    push_bead(32'h0, 32'h0, 32'h0, 1);
    push_bead(32'h5_0000, 32'h5_0000, 32'h5_0000, 0);
    push_bead(32'h5_0000, 32'h5_0000, 32'h5_0000, 0);
    push_bead(32'h6_0000, 32'h5_0000, 32'h5_0000, 1);
    push_bead(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    push_bead(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    push_bead(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    push_bead(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    push_bead(32'hFFFF_FFFF, 32'h0, 32'h1, 0);
    push_bead(32'h0, 32'hFFFF_FFFF, 32'h1, 0);
    push_bead(32'h1, 32'h0, 32'hFFFF_FFFF, 1);
    drain();

    // out-of-range index is ignored
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= 2'd3;
    cfg_data <= 24'hFF_FFFF;
    @(posedge clk);
    cfg_we <= 0;

    write_regs(24'hFF_FFFF, 24'h0, 24'hFF_FFFF);
    random_phase(200);

    write_regs(24'h0, 24'h0, 24'h0);
    hold_go = 1;
    random_phase(120);

    write_regs(24'($urandom), 24'($urandom), 24'($urandom));
    random_phase(250);

    write_regs(24'hFF_FFFF, 24'hFF_FFFF, 24'h0);
    random_phase(150);

    write_regs(ces_pkg::CFG_ONE, 24'($urandom_range(0, 24'h4_0000)), 24'($urandom));
    quiet = 1;
    random_phase(330);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== chain_energy_spring_bend.f =====
design/ces_pkg.sv
design/ces_mul.sv
design/ces_div.sv
design/chain_energy_spring_bend.sv
tb/tb_chain_energy_spring_bend.sv
